// ===== rtl/core/sar_pkg.sv =====
// ----------------------------------------------------------------------------
// sar_pkg
// Shared types, register codes and unit sizes for the seek-and-arrive
// steering datapath.
// ----------------------------------------------------------------------------
package sar_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOWING_DISTANCE = 2'd1;

  localparam logic [30:0] TOP_SPEED_RESET = 31'd65536;

  localparam int SQRT_IN_W = 78;
  localparam int SQRT_LAT = SQRT_IN_W / 2;
  localparam int SQRT_REM_W = SQRT_LAT + 2;

  localparam int DIV_LAT = 31;
  localparam int DIV_DEN_W = 39;
  localparam int DIV_NUM_W = DIV_DEN_W - 1 + DIV_LAT;

  localparam int PIPE_LAT = 3 + SQRT_LAT + 1 + DIV_LAT + 2 + DIV_LAT + 8 + SQRT_LAT + 2
                            + DIV_LAT + 1;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [31:0] target_x;
    logic [31:0] target_y;
    logic [31:0] target_z;
    logic [19:0] delta_time;
  } req_t;

  typedef struct packed {
    logic [31:0] new_vel_x;
    logic [31:0] new_vel_y;
    logic [31:0] new_vel_z;
  } res_t;

endpackage

// ===== rtl/core/seek_arrive_steering_step.sv =====
// ----------------------------------------------------------------------------
// seek_arrive_steering_step
// A request passes through every pipeline stage and then the output register.
// Throughput: one request per cycle unless a held result stalls the pipeline;
// the two square roots and the dividers are fully pipelined, one result bit per stage.
// Reset clears all valid bits, including the output register's, and sets
// top_speed to 1.0 and slowing_distance to 0. Configuration writes are taken
// every cycle.
// ----------------------------------------------------------------------------
module seek_arrive_steering_step
  import sar_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_t                  res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef struct packed {
    logic [2:0][32:0] dmag;
    logic [2:0]       dneg;
    logic [2:0][31:0] vel;
    logic [19:0]      dt;
  } side_a_t;

  typedef struct packed {
    logic [32:0] dlen;
    side_a_t     sa;
  } side_b_t;

  typedef struct packed {
    logic             dz;
    logic [2:0]       dneg;
    logic [2:0][31:0] vel;
    logic [19:0]      dt;
  } side_c_t;

  typedef struct packed {
    logic             clamp;
    logic [2:0][37:0] vmag;
    logic [2:0]       vneg;
  } side_d_t;

  logic [30:0] top_speed;
  logic [30:0] slowing_distance;
  logic [61:0] top_sq;
  logic        adv;
  logic [PIPE_LAT-1:0] vld;

  logic signed [31:0] pos_a [3];
  logic signed [31:0] tgt_a [3];

  logic signed [32:0] d_s1 [3];
  logic [2:0][31:0]   vel_s1;
  logic [19:0]        dt_s1;

  logic [65:0] sq_s2 [3];
  side_a_t     sa_s2;
  logic [65:0] sum_s3;
  side_a_t     sa_s3;

  logic [SQRT_LAT-1:0] root1;
  side_a_t             sa_q [SQRT_LAT];

  logic [32:0] dist_p1;
  logic [63:0] prod_p1;
  side_a_t     sa_p1;
  logic [DIV_LAT-1:0] q1;
  side_b_t     sb_q [DIV_LAT];

  logic [30:0] s_p2;
  side_b_t     sb_p2;

  logic [63:0] num_p3 [3];
  logic [32:0] dist_p3;
  side_c_t     sc_p3;
  logic [DIV_LAT-1:0] des [3];
  side_c_t     sc_q [DIV_LAT];

  logic signed [33:0] st_c [3];
  logic signed [33:0] st_p4 [3];
  logic [2:0][31:0]   vel_p4;
  logic [19:0]        dt_p4;

  logic signed [53:0] prod_p5 [3];
  logic [2:0][31:0]   vel_p5;

  logic [36:0]        ms_p6 [3];
  logic [2:0]         mneg_p6;
  logic [2:0][31:0]   vel_p6;

  logic signed [38:0] v_p7 [3];
  logic [2:0][37:0]   vmag_p8, vmag_p9, vmag_p10, vmag_p11;
  logic [2:0]         vneg_p8, vneg_p9, vneg_p10, vneg_p11;
  logic [37:0]        hh_p9 [3];
  logic [37:0]        hl_p9 [3];
  logic [37:0]        ll_p9 [3];
  logic [75:0]        sq_p10 [3];
  logic [77:0]        lsum_p11;

  logic [SQRT_LAT-1:0] root2;
  side_d_t             sd_in;
  side_d_t             sd_q [SQRT_LAT];

  logic [38:0] len_c1;
  logic [49:0] ph_c1 [3];
  logic [49:0] pl_c1 [3];
  side_d_t     sd_c1;
  logic [68:0] num_c2 [3];
  logic [38:0] len_c2;
  side_d_t     sd_c2;
  logic [DIV_LAT-1:0] quo [3];
  side_d_t     se_q [DIV_LAT];

  logic [2:0][31:0] out_c;
  res_t             res_c3;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_speed        <= TOP_SPEED_RESET;
      slowing_distance <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TOP_SPEED:        top_speed        <= cfg_data[30:0];
        REG_SLOWING_DISTANCE: slowing_distance <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    top_sq <= 62'(top_speed * top_speed);
  end

  // The pipeline moves unless its last stage and the output register are
  // both full and the output is not taken.
  assign adv       = !vld[PIPE_LAT-1] || !res_valid || res_ready;
  assign req_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LAT-2:0], req_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv && vld[PIPE_LAT-1]) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld[PIPE_LAT-1]) begin
      res <= res_c3;
    end
  end

  assign pos_a[0] = req.pos_x;
  assign pos_a[1] = req.pos_y;
  assign pos_a[2] = req.pos_z;
  assign tgt_a[0] = req.target_x;
  assign tgt_a[1] = req.target_y;
  assign tgt_a[2] = req.target_z;

  // Offset, squared distance.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_s1[i] <= {tgt_a[i][31], tgt_a[i]} - {pos_a[i][31], pos_a[i]};
      end
      vel_s1 <= {req.vel_z, req.vel_y, req.vel_x};
      dt_s1  <= req.delta_time;

      for (int i = 0; i < 3; i++) begin
        sq_s2[i]       <= 66'(d_s1[i] * d_s1[i]);
        sa_s2.dmag[i]  <= d_s1[i][32] ? 33'(-d_s1[i]) : 33'(d_s1[i]);
        sa_s2.dneg[i]  <= d_s1[i][32];
      end
      sa_s2.vel <= vel_s1;
      sa_s2.dt  <= dt_s1;

      sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
      sa_s3  <= sa_s2;

      sa_q[0] <= sa_s3;
      for (int k = 1; k < SQRT_LAT; k++) begin
        sa_q[k] <= sa_q[k-1];
      end
    end
  end

  sar_sqrt u_sqrt_dist (
    .clk  (clk),
    .en   (adv),
    .rad  ({(SQRT_IN_W - 66)'(0), sum_s3}),
    .root (root1)
  );

  // Arrival slowing: top speed, scaled by distance over slowing distance inside it.
  always_ff @(posedge clk) begin
    if (adv) begin
      dist_p1 <= root1[32:0];
      prod_p1 <= 64'(top_speed * root1[32:0]);
      sa_p1   <= sa_q[SQRT_LAT-1];

      sb_q[0] <= {dist_p1, sa_p1};
      for (int k = 1; k < DIV_LAT; k++) begin
        sb_q[k] <= sb_q[k-1];
      end

      if (slowing_distance != '0 && sb_q[DIV_LAT-1].dlen < {2'b00, slowing_distance}) begin
        s_p2 <= q1;
      end else begin
        s_p2 <= top_speed;
      end
      sb_p2 <= sb_q[DIV_LAT-1];

      for (int i = 0; i < 3; i++) begin
        num_p3[i] <= 64'(sb_p2.sa.dmag[i] * s_p2);
      end
      dist_p3    <= sb_p2.dlen;
      sc_p3.dz   <= (sb_p2.dlen == '0);
      sc_p3.dneg <= sb_p2.sa.dneg;
      sc_p3.vel  <= sb_p2.sa.vel;
      sc_p3.dt   <= sb_p2.sa.dt;

      sc_q[0] <= sc_p3;
      for (int k = 1; k < DIV_LAT; k++) begin
        sc_q[k] <= sc_q[k-1];
      end
    end
  end

  sar_div u_div_slow (
    .clk (clk),
    .en  (adv),
    .num ({(DIV_NUM_W - 64)'(0), prod_p1}),
    .den ({(DIV_DEN_W - 31)'(0), slowing_distance}),
    .quo (q1)
  );

  for (genvar i = 0; i < 3; i++) begin : g_des
    sar_div u_div_des (
      .clk (clk),
      .en  (adv),
      .num ({(DIV_NUM_W - 64)'(0), num_p3[i]}),
      .den ({(DIV_DEN_W - 33)'(0), dist_p3}),
      .quo (des[i])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [33:0] des_s;
      logic signed [31:0] vel_i;
      des_s = $signed({3'b000, des[i]});
      vel_i = sc_q[DIV_LAT-1].vel[i];
      if (sc_q[DIV_LAT-1].dz) begin
        des_s = '0;
      end else if (sc_q[DIV_LAT-1].dneg[i]) begin
        des_s = -des_s;
      end
      st_c[i] = des_s - 34'(vel_i);
    end
  end

  // Velocity step, then the squared length of the new velocity.
  always_ff @(posedge clk) begin
    if (adv) begin
      st_p4  <= st_c;
      vel_p4 <= sc_q[DIV_LAT-1].vel;
      dt_p4  <= sc_q[DIV_LAT-1].dt;

      for (int i = 0; i < 3; i++) begin
        prod_p5[i] <= 54'(st_p4[i] * $signed({1'b0, dt_p4}));
      end
      vel_p5 <= vel_p4;

      for (int i = 0; i < 3; i++) begin
        mneg_p6[i] <= prod_p5[i][53];
        ms_p6[i]   <= prod_p5[i][53] ? 37'((-prod_p5[i]) >>> 16) : 37'(prod_p5[i] >>> 16);
      end
      vel_p6 <= vel_p5;

      for (int i = 0; i < 3; i++) begin
        v_p7[i] <= mneg_p6[i] ? 39'($signed(vel_p6[i])) - $signed({2'b00, ms_p6[i]})
                              : 39'($signed(vel_p6[i])) + $signed({2'b00, ms_p6[i]});
      end

      for (int i = 0; i < 3; i++) begin
        vneg_p8[i] <= v_p7[i][38];
        vmag_p8[i] <= v_p7[i][38] ? 38'(-v_p7[i]) : 38'(v_p7[i]);
      end

      for (int i = 0; i < 3; i++) begin
        hh_p9[i] <= vmag_p8[i][37:19] * vmag_p8[i][37:19];
        hl_p9[i] <= vmag_p8[i][37:19] * vmag_p8[i][18:0];
        ll_p9[i] <= vmag_p8[i][18:0] * vmag_p8[i][18:0];
      end
      vmag_p9 <= vmag_p8;
      vneg_p9 <= vneg_p8;

      for (int i = 0; i < 3; i++) begin
        sq_p10[i] <= {hh_p9[i], 38'd0} + {18'd0, hl_p9[i], 20'd0} + {38'd0, ll_p9[i]};
      end
      vmag_p10 <= vmag_p9;
      vneg_p10 <= vneg_p9;

      lsum_p11 <= {2'b00, sq_p10[0]} + {2'b00, sq_p10[1]} + {2'b00, sq_p10[2]};
      vmag_p11 <= vmag_p10;
      vneg_p11 <= vneg_p10;
    end
  end

  assign sd_in.clamp = (lsum_p11 > {16'd0, top_sq});
  assign sd_in.vmag  = vmag_p11;
  assign sd_in.vneg  = vneg_p11;

  sar_sqrt u_sqrt_len (
    .clk  (clk),
    .en   (adv),
    .rad  (lsum_p11),
    .root (root2)
  );

  // Length clamp: v * top_speed / len when len exceeds top_speed.
  always_ff @(posedge clk) begin
    if (adv) begin
      sd_q[0] <= sd_in;
      for (int k = 1; k < SQRT_LAT; k++) begin
        sd_q[k] <= sd_q[k-1];
      end

      len_c1 <= root2;
      for (int i = 0; i < 3; i++) begin
        ph_c1[i] <= sd_q[SQRT_LAT-1].vmag[i][37:19] * top_speed;
        pl_c1[i] <= sd_q[SQRT_LAT-1].vmag[i][18:0] * top_speed;
      end
      sd_c1 <= sd_q[SQRT_LAT-1];

      for (int i = 0; i < 3; i++) begin
        num_c2[i] <= {ph_c1[i], 19'd0} + {19'd0, pl_c1[i]};
      end
      len_c2 <= len_c1;
      sd_c2  <= sd_c1;

      se_q[0] <= sd_c2;
      for (int k = 1; k < DIV_LAT; k++) begin
        se_q[k] <= se_q[k-1];
      end

      res_c3 <= {out_c[0], out_c[1], out_c[2]};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_clamp
    sar_div u_div_clamp (
      .clk (clk),
      .en  (adv),
      .num (num_c2[i]),
      .den (len_c2),
      .quo (quo[i])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [37:0] m;
      logic [38:0] neg_m;
      logic        neg;
      m     = se_q[DIV_LAT-1].clamp ? {7'd0, quo[i]} : se_q[DIV_LAT-1].vmag[i];
      neg   = se_q[DIV_LAT-1].vneg[i];
      neg_m = -{1'b0, m};
      if (!neg) begin
        out_c[i] = (|m[37:31]) ? 32'h7FFF_FFFF : m[31:0];
      end else if (|m[37:32] || (m[31] && |m[30:0])) begin
        out_c[i] = 32'h8000_0000;
      end else begin
        out_c[i] = neg_m[31:0];
      end
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (vld[PIPE_LAT-1] && res_valid && !res_ready))
    else $error("pipeline stalled without a blocked result");

  a_load_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(vld[PIPE_LAT-1]))
    else $error("result appeared without a finished request");

  a_last_delivered: assert property (@(posedge clk) disable iff (rst)
    (adv && vld[PIPE_LAT-1]) |=> res_valid)
    else $error("finished request was not moved to the output");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!res_valid && $countones(vld) == 0))
    else $error("reset left valid state behind");

endmodule

// ===== rtl/core/sar_sqrt.sv =====
// ----------------------------------------------------------------------------
// sar_sqrt
// Pipelined integer square root: one result bit per stage, floor of the root.
// ----------------------------------------------------------------------------
module sar_sqrt
  import sar_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [SQRT_IN_W-1:0] rad,
  output logic [SQRT_LAT-1:0]  root
);

  logic [SQRT_IN_W-1:0]  rad_q  [SQRT_LAT];
  logic [SQRT_REM_W-1:0] rem_q  [SQRT_LAT];
  logic [SQRT_LAT-1:0]   root_q [SQRT_LAT];

  for (genvar i = 0; i < SQRT_LAT; i++) begin : g_stage
    logic [SQRT_IN_W-1:0]  rad_in;
    logic [SQRT_REM_W-1:0] rem_in;
    logic [SQRT_LAT-1:0]   root_in;
    logic [SQRT_REM_W+1:0] r2;
    logic [SQRT_REM_W+1:0] trial;
    logic                  ge;

    if (i == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    assign r2    = {rem_in, rad_in[SQRT_IN_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[i]  <= {rad_in[SQRT_IN_W-3:0], 2'b00};
        rem_q[i]  <= ge ? SQRT_REM_W'(r2 - trial) : r2[SQRT_REM_W-1:0];
        root_q[i] <= {root_in[SQRT_LAT-2:0], ge};
      end
    end
  end

  assign root = root_q[SQRT_LAT-1];

endmodule

// ===== rtl/core/sar_div.sv =====
// ----------------------------------------------------------------------------
// sar_div
// Pipelined restoring divider: one quotient bit per stage. The quotient must
// fit in DIV_LAT bits.
// ----------------------------------------------------------------------------
module sar_div
  import sar_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_LAT-1:0]   quo
);

  logic [DIV_DEN_W-1:0] rem_q [DIV_LAT];
  logic [DIV_LAT-1:0]   lo_q  [DIV_LAT];
  logic [DIV_LAT-1:0]   quo_q [DIV_LAT];
  logic [DIV_DEN_W-1:0] den_q [DIV_LAT];

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_stage
    logic [DIV_DEN_W-1:0] rem_in;
    logic [DIV_LAT-1:0]   lo_in;
    logic [DIV_LAT-1:0]   quo_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_DEN_W:0]   r2;
    logic                 ge;

    if (i == 0) begin : g_first
      assign rem_in = {1'b0, num[DIV_NUM_W-1:DIV_LAT]};
      assign lo_in  = num[DIV_LAT-1:0];
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign lo_in  = lo_q[i-1];
      assign quo_in = quo_q[i-1];
      assign den_in = den_q[i-1];
    end

    assign r2 = {rem_in, lo_in[DIV_LAT-1]};
    assign ge = (r2 >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= ge ? DIV_DEN_W'(r2 - {1'b0, den_in}) : r2[DIV_DEN_W-1:0];
        lo_q[i]  <= {lo_in[DIV_LAT-2:0], 1'b0};
        quo_q[i] <= {quo_in[DIV_LAT-2:0], ge};
        den_q[i] <= den_in;
      end
    end
  end

  assign quo = quo_q[DIV_LAT-1];

endmodule
